### src/acb_pkg.sv
// Shared types, status codes and the fixed item size table of the CAT065
// block checker. No dependencies.
package acb_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [BYTE_W-1:0] CAT_RESET = 8'd65;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CATEGORY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEN_EXCEEDS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FSPEC_CUT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SPARE       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EXTRA_FSPEC = 3'd6;
    localparam logic [STATUS_W-1:0] ST_OVERRUN     = 3'd7;

    // FSPEC bits
    localparam logic [BYTE_W-1:0] BIT_FX     = 8'h01;
    localparam logic [BYTE_W-1:0] BIT_SP     = 8'h02;
    localparam logic [BYTE_W-1:0] BIT_RE     = 8'h04;
    localparam logic [BYTE_W-1:0] SPARE_MASK = 8'hF8;

    localparam logic [16:0] MAX_BLOCK = 17'h0FFFF;
    localparam logic [16:0] COUNT_SAT = 17'h10000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                length_warning;
    } result_t;

    // sizes of I010, I000, I015, I030, I020, I040, I050 (FSPEC bits 7..1)
    localparam logic [1:0] FIX_SIZE [7] = '{2'd2, 2'd1, 2'd1, 2'd3, 2'd1, 2'd1, 2'd1};

    function automatic logic [BYTE_W-1:0] fixed_total(input logic [BYTE_W-1:0] fspec);
        logic [BYTE_W-1:0] total;
        total = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (fspec[7-i])
                total = total + {6'd0, FIX_SIZE[i]};
        end
        return total;
    endfunction

endpackage

### src/acb_if.sv
// Channel interfaces of the CAT065 block checker: byte stream, result, config.
// Depends on acb_pkg.
interface acb_byte_if import acb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface acb_result_if import acb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                length_warning;

    modport source (output valid, output status, output length_warning, input ready);
    modport sink   (input valid, input status, input length_warning, output ready);
endinterface

interface acb_cfg_if import acb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/acb_parser.sv
// Block parse state and its one-byte update; gives the block status on the
// last byte. Depends on acb_pkg.
module acb_parser import acb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last,
    input  logic [BYTE_W-1:0] expected_category,
    output result_t           result
);

    localparam logic [3:0] PH_CAT      = 4'd0;
    localparam logic [3:0] PH_LEN_HI   = 4'd1;
    localparam logic [3:0] PH_LEN_LO   = 4'd2;
    localparam logic [3:0] PH_FSPEC    = 4'd3;
    localparam logic [3:0] PH_SKIP_FIX = 4'd4;
    localparam logic [3:0] PH_RE_LEN   = 4'd5;
    localparam logic [3:0] PH_RE_SKIP  = 4'd6;
    localparam logic [3:0] PH_SP_LEN   = 4'd7;
    localparam logic [3:0] PH_SP_SKIP  = 4'd8;
    localparam logic [3:0] PH_DONE     = 4'd9;

    logic [16:0]         cnt_reg, cnt_upd, cnt_next;
    logic [15:0]         decl_reg, decl_upd, decl_next;
    logic [3:0]          phase_reg, phase_upd, phase_next;
    logic [BYTE_W-1:0]   fs1_reg, fs1_upd, fs1_next;
    logic [BYTE_W-1:0]   fs2_reg, fs2_upd, fs2_next;
    logic [1:0]          fpos_reg, fpos_upd, fpos_next;
    logic [BYTE_W-1:0]   skip_reg, skip_upd, skip_next;
    logic [STATUS_W-1:0] pend_reg, pend_upd, pend_next;
    logic [STATUS_W-1:0] ferr_reg, ferr_upd, ferr_next;

    logic              adv_req;
    logic [1:0]        adv_stage;
    logic [BYTE_W-1:0] fix_total;
    logic [BYTE_W-1:0] item_len;

    // first FSPEC byte of the record as seen by the FSPEC phase
    assign fix_total = fixed_total((fpos_reg == 2'd0) ? data_byte : fs1_reg);
    assign item_len  = (data_byte == '0) ? 8'd1 : data_byte;

    always_comb
    begin
        cnt_upd   = (cnt_reg < COUNT_SAT) ? cnt_reg + 17'd1 : cnt_reg;
        decl_upd  = decl_reg;
        phase_upd = phase_reg;
        fs1_upd   = fs1_reg;
        fs2_upd   = fs2_reg;
        fpos_upd  = fpos_reg;
        skip_upd  = skip_reg;
        pend_upd  = pend_reg;
        ferr_upd  = ferr_reg;
        adv_req   = 1'b0;
        adv_stage = 2'd0;

        unique case (phase_reg) inside
            PH_CAT:
            begin
                if (data_byte != expected_category)
                begin
                    ferr_upd  = ST_CATEGORY;
                    phase_upd = PH_DONE;
                end
                else
                begin
                    phase_upd = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                decl_upd  = {data_byte, 8'd0};
                phase_upd = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                decl_upd  = {decl_reg[15:8], data_byte};
                phase_upd = PH_FSPEC;
                fs1_upd   = '0;
                fs2_upd   = '0;
                fpos_upd  = '0;
                pend_upd  = ST_OK;
                skip_upd  = '0;
            end
            PH_FSPEC:
            begin
                if (fpos_reg == 2'd0)
                begin
                    fs1_upd = data_byte;
                end
                else if (fpos_reg == 2'd1)
                begin
                    fs2_upd = data_byte;
                    if ((data_byte & SPARE_MASK) != '0)
                        pend_upd = ST_SPARE;
                    else if ((data_byte & BIT_FX) != '0)
                        pend_upd = ST_EXTRA_FSPEC;
                end
                if (fpos_reg != 2'd3)
                    fpos_upd = fpos_reg + 2'd1;
                if ((data_byte & BIT_FX) == '0)
                begin
                    if (pend_upd != ST_OK)
                    begin
                        ferr_upd  = pend_upd;
                        phase_upd = PH_DONE;
                    end
                    else if (fix_total != '0)
                    begin
                        skip_upd  = fix_total;
                        phase_upd = PH_SKIP_FIX;
                    end
                    else
                    begin
                        adv_req   = 1'b1;
                        adv_stage = 2'd0;
                    end
                end
            end
            PH_RE_LEN, PH_SP_LEN:
            begin
                skip_upd  = item_len - 8'd1;
                adv_stage = (phase_reg == PH_RE_LEN) ? 2'd1 : 2'd2;
                if (skip_upd != '0)
                    phase_upd = (phase_reg == PH_RE_LEN) ? PH_RE_SKIP : PH_SP_SKIP;
                else
                    adv_req = 1'b1;
            end
            PH_SKIP_FIX, PH_RE_SKIP, PH_SP_SKIP:
            begin
                if (skip_reg != '0)
                    skip_upd = skip_reg - 8'd1;
                if (skip_upd == '0)
                    adv_req = 1'b1;
                adv_stage = (phase_reg == PH_SKIP_FIX) ? 2'd0 :
                            (phase_reg == PH_RE_SKIP)  ? 2'd1 : 2'd2;
            end
            default:
            begin
                phase_upd = PH_DONE;
            end
        endcase

        // move on to RE, then SP, then the next record
        if (adv_req)
        begin
            if (adv_stage < 2'd1 && (fs2_upd & BIT_RE) != '0)
            begin
                phase_upd = PH_RE_LEN;
            end
            else if (adv_stage < 2'd2 && (fs2_upd & BIT_SP) != '0)
            begin
                phase_upd = PH_SP_LEN;
            end
            else
            begin
                phase_upd = PH_FSPEC;
                fs1_upd   = '0;
                fs2_upd   = '0;
                fpos_upd  = '0;
                pend_upd  = ST_OK;
                skip_upd  = '0;
            end
        end
    end

    // block status from the updated state
    always_comb
    begin
        if (cnt_upd < 17'd3 || cnt_upd > MAX_BLOCK)
            result.status = ST_SIZE;
        else if (ferr_upd == ST_CATEGORY)
            result.status = ST_CATEGORY;
        else if ({1'b0, decl_upd} > cnt_upd)
            result.status = ST_LEN_EXCEEDS;
        else if (ferr_upd != ST_OK)
            result.status = ferr_upd;
        else if (phase_upd == PH_FSPEC && fpos_upd == 2'd0)
            result.status = ST_OK;
        else if (phase_upd == PH_FSPEC)
            result.status = ST_FSPEC_CUT;
        else
            result.status = ST_OVERRUN;
        result.length_warning = (result.status != ST_SIZE)
                             && (result.status != ST_CATEGORY)
                             && ({1'b0, decl_upd} < cnt_upd);
    end

    always_comb
    begin
        if (!step)
        begin
            cnt_next   = cnt_reg;
            decl_next  = decl_reg;
            phase_next = phase_reg;
            fs1_next   = fs1_reg;
            fs2_next   = fs2_reg;
            fpos_next  = fpos_reg;
            skip_next  = skip_reg;
            pend_next  = pend_reg;
            ferr_next  = ferr_reg;
        end
        else if (last)
        begin
            cnt_next   = '0;
            decl_next  = '0;
            phase_next = PH_CAT;
            fs1_next   = '0;
            fs2_next   = '0;
            fpos_next  = '0;
            skip_next  = '0;
            pend_next  = ST_OK;
            ferr_next  = ST_OK;
        end
        else
        begin
            cnt_next   = cnt_upd;
            decl_next  = decl_upd;
            phase_next = phase_upd;
            fs1_next   = fs1_upd;
            fs2_next   = fs2_upd;
            fpos_next  = fpos_upd;
            skip_next  = skip_upd;
            pend_next  = pend_upd;
            ferr_next  = ferr_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            decl_reg  <= '0;
            phase_reg <= PH_CAT;
            fs1_reg   <= '0;
            fs2_reg   <= '0;
            fpos_reg  <= '0;
            skip_reg  <= '0;
            pend_reg  <= ST_OK;
            ferr_reg  <= ST_OK;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            decl_reg  <= decl_next;
            phase_reg <= phase_next;
            fs1_reg   <= fs1_next;
            fs2_reg   <= fs2_next;
            fpos_reg  <= fpos_next;
            skip_reg  <= skip_next;
            pend_reg  <= pend_next;
            ferr_reg  <= ferr_next;
        end
    end

`ifndef ASSERT_OFF
    // the last byte always hands the next block a clean header state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (phase_reg == PH_CAT && cnt_reg == '0))
        else $error("parser did not restart after last byte");

    // skip phases always hold a nonzero count
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP_FIX || phase_reg == PH_RE_SKIP || phase_reg == PH_SP_SKIP)
        |-> (skip_reg != '0))
        else $error("skip phase with zero count");

    // a record error is only latched together with the done phase
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ferr_reg != ST_OK) |-> (phase_reg == PH_DONE))
        else $error("error recorded while still parsing");
`endif

endmodule

### src/asterix_cat065_block_checker_top.sv
// Top level of the CAT065 block checker: input byte register, parser and
// result register. Depends on acb_pkg, acb_if and acb_parser.
//
// Usage:
//   byte_stream  sink of data block bytes, last marks the final byte.
//   result       source of one status request per block, sent after the
//                last byte: status code and length_warning.
//   cfg          write of expected_category; always ready. Write it only
//                while no block is in flight.
// Timing: an accepted byte is held in the input register and parsed from there;
//   the status of a block is valid on result right after the edge that parses
//   its last byte.
// Throughput: one byte per cycle while byte_stream.ready is high, set by the
//   parser update between the input register and the parse state registers.
// Stall: while a status waits unread, bytes of the next block keep flowing;
//   only a further last byte waits in the input register until the result
//   is taken, which drops byte_stream.ready.
// Reset: rst_n clears all parse state and both valid flags;
//   expected_category returns to 65.
module asterix_cat065_block_checker_top import acb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    acb_byte_if.sink     byte_stream,
    acb_result_if.source result,
    acb_cfg_if.sink      cfg
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              in_last_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic [BYTE_W-1:0] cat_reg;

    logic    stall;
    logic    step;
    logic    in_take;
    result_t parse_result;

    // a last byte cannot be parsed while the previous status is unread
    assign stall   = in_valid_reg && in_last_reg && out_valid_reg && !result.ready;
    assign step    = in_valid_reg && !stall;
    assign in_take = byte_stream.valid && !stall;

    assign byte_stream.ready = !stall;

    assign in_valid_next = stall ? in_valid_reg : byte_stream.valid;

    always_comb
    begin
        if (step && in_last_reg)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cat_reg       <= CAT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                cat_reg <= cfg.data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last;
        end
        if (step && in_last_reg)
            out_reg <= parse_result;
    end

    assign cfg.ready = 1'b1;

    acb_parser u_parser
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .data_byte         (in_byte_reg),
        .last              (in_last_reg),
        .expected_category (cat_reg),
        .result            (parse_result)
    );

    assign result.valid          = out_valid_reg;
    assign result.status         = out_reg.status;
    assign result.length_warning = out_reg.length_warning;

`ifndef ASSERT_OFF
    // a parsed last byte always produces a pending status
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_last_reg) |=> out_valid_reg)
        else $error("last byte parsed without a status");

    // no warning when the length check was never reached or failed
    a_warn_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ST_SIZE || out_reg.status == ST_CATEGORY
                           || out_reg.status == ST_LEN_EXCEEDS))
        |-> !out_reg.length_warning)
        else $error("length warning with size, category or length error");

    // backpressure only comes from a last byte stuck behind an unread status
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_stream.ready |-> (in_valid_reg && in_last_reg && out_valid_reg))
        else $error("input stalled without a waiting last byte");
`endif

endmodule
